>>> hdl/ptach_pkg.sv
// Shared types and constants for the pulse period tachometer.
// Used by the controller, the datapath and the top level; no dependencies.
package ptach_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned RpmWidth   = 26;
  localparam int unsigned PprWidth   = 8;
  localparam int unsigned DivWidth   = CountWidth + PprWidth;
  localparam int unsigned DivSteps   = RpmWidth;
  localparam int unsigned StepWidth  = $clog2(DivSteps);

  localparam logic [RpmWidth-1:0]  RpmNumerator = 26'd60000000;
  localparam logic [StepWidth-1:0] LastStep     = StepWidth'(DivSteps - 1);

  typedef struct packed {
    logic take;
    logic mul;
    logic div_step;
    logic div_last;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic out_free;
  } stat_t;

endpackage

>>> hdl/ptach_ctrl.sv
// Controller state machine for the pulse period tachometer.
// Depends on ptach_pkg; drives commands into ptach_datapath.
module ptach_ctrl import ptach_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOAD
  } state_t;

  state_t                state;
  logic [StepWidth-1:0]  step;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.take     = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.div_last = (state == S_DIV) && (step == '0);
    cmd.load_out = (state == S_LOAD) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.div_needed ? S_MUL : S_LOAD;
          end
        end
        S_MUL: begin
          step  <= LastStep;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            state <= S_LOAD;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_LOAD: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ptach_datapath.sv
// Datapath for the pulse period tachometer: edge detection, counters,
// the restoring divider and the output register. Depends on ptach_pkg.
module ptach_datapath import ptach_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PprWidth-1:0]   cfg_wdata,
  input  logic                  sensor_level,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pulse_event,
  output logic [CountWidth-1:0] pulse_total,
  output logic [CountWidth-1:0] period_ticks,
  output logic [RpmWidth-1:0]   rpm_value,
  output logic                  rpm_valid
);

  logic [PprWidth-1:0]   ppr_cfg;
  logic                  prev_level;
  logic                  primed;
  logic                  seen_first_edge;
  logic [CountWidth-1:0] ticks_since_edge;
  logic [CountWidth-1:0] edge_count;
  logic [CountWidth-1:0] held_period;
  logic [RpmWidth-1:0]   held_rpm;
  logic                  have_period;
  logic                  last_event;

  logic [DivWidth-1:0]   divisor;
  logic [RpmWidth-1:0]   rem;
  logic [RpmWidth-1:0]   quo;

  logic                  falling;
  logic [CountWidth-1:0] ticks_inc;
  logic [PprWidth-1:0]   ppr_eff;
  logic [RpmWidth:0]     rem_shift;
  logic                  fits;
  logic [RpmWidth-1:0]   rem_next;
  logic [RpmWidth-1:0]   quo_next;

  assign falling   = primed && prev_level && !sensor_level;
  assign ticks_inc = (ticks_since_edge == '1) ? ticks_since_edge
                                              : ticks_since_edge + 1'b1;
  assign ppr_eff   = (ppr_cfg == '0) ? PprWidth'(1) : ppr_cfg;

  assign rem_shift = {rem, quo[RpmWidth-1]};
  assign fits      = DivWidth'(rem_shift) >= divisor;
  assign rem_next  = fits ? RpmWidth'(DivWidth'(rem_shift) - divisor)
                          : rem_shift[RpmWidth-1:0];
  assign quo_next  = {quo[RpmWidth-2:0], fits};

  assign stat.div_needed = falling && seen_first_edge;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr_cfg          <= PprWidth'(1);
      prev_level       <= 1'b1;
      primed           <= 1'b0;
      seen_first_edge  <= 1'b0;
      ticks_since_edge <= '0;
      edge_count       <= '0;
      held_period      <= '0;
      held_rpm         <= '0;
      have_period      <= 1'b0;
      last_event       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        ppr_cfg <= cfg_wdata;
      end
      if (cmd.take) begin
        prev_level <= sensor_level;
        primed     <= 1'b1;
        last_event <= falling;
        if (primed) begin
          if (falling) begin
            edge_count       <= edge_count + 1'b1;
            seen_first_edge  <= 1'b1;
            ticks_since_edge <= '0;
            if (seen_first_edge) begin
              held_period <= ticks_inc;
              have_period <= 1'b1;
            end
          end else begin
            ticks_since_edge <= ticks_inc;
          end
        end
      end
      if (cmd.div_last) begin
        held_rpm <= quo_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      divisor <= held_period * ppr_eff;
      rem     <= '0;
      quo     <= RpmNumerator;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.load_out) begin
      pulse_event  <= last_event;
      pulse_total  <= edge_count;
      period_ticks <= held_period;
      rpm_value    <= held_rpm;
      rpm_valid    <= have_period;
    end
  end

endmodule

>>> hdl/pulse_period_tachometer.sv
// Pulse period tachometer: a falling edge that ends a period passes a multiply
// state and a 26-step restoring divider for the rpm before the output load.
// Requests are taken only in the idle state, so a new one waits until the last
// is loaded; a stalled output register holds off that load and the next request.
// Synchronous reset sets the pulses per revolution to 1 and clears the control,
// counter and output-valid state, but not the divider or output data registers.
module pulse_period_tachometer import ptach_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PprWidth-1:0]   cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  sensor_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pulse_event,
  output logic [CountWidth-1:0] pulse_total,
  output logic [CountWidth-1:0] period_ticks,
  output logic [RpmWidth-1:0]   rpm_value,
  output logic                  rpm_valid
);

  cmd_t  cmd;
  stat_t stat;

  ptach_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptach_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sensor_level (sensor_level),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_event  (pulse_event),
    .pulse_total  (pulse_total),
    .period_ticks (period_ticks),
    .rpm_value    (rpm_value),
    .rpm_valid    (rpm_valid)
  );

endmodule

>>> hdl/ptach_checker.sv
// Port-level checks for the pulse period tachometer and the bind that
// attaches them. Depends on ptach_pkg and pulse_period_tachometer.
module ptach_checker import ptach_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  pulse_event,
  input logic [CountWidth-1:0] pulse_total,
  input logic [CountWidth-1:0] period_ticks,
  input logic [RpmWidth-1:0]   rpm_value,
  input logic                  rpm_valid
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output request is valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_total) &&
      $stable(period_ticks) && $stable(rpm_value) && $stable(pulse_event))
    else $error("Stalled output request changed.");

  a_rpm_has_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && rpm_valid |-> period_ticks != '0)
    else $error("Rpm reported valid with a zero period.");

  a_rpm_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && rpm_valid |=> !out_valid || rpm_valid)
    else $error("Rpm valid dropped after it was set.");

endmodule

bind pulse_period_tachometer ptach_checker u_ptach_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pulse_event  (pulse_event),
  .pulse_total  (pulse_total),
  .period_ticks (period_ticks),
  .rpm_value    (rpm_value),
  .rpm_valid    (rpm_valid)
);

>>> tb/sv/pulse_period_tachometer_tb.sv
// Self-checking testbench for the pulse period tachometer.
// Tick requests come from a queue; every result is checked against a tracked copy of the state.
// Depends on ptach_pkg and the pulse_period_tachometer RTL.
`timescale 1ns / 1ps

module pulse_period_tachometer_tb;
  import ptach_pkg::*;

  localparam longint unsigned RpmScale = 60000000;
  localparam int NumPhases = 8;
  localparam int TicksPerPhase = 120;

  typedef struct packed {
    logic                  fell;
    logic [CountWidth-1:0] total;
    logic [CountWidth-1:0] period;
    logic [RpmWidth-1:0]   rpm;
    logic                  rpm_ok;
  } tach_reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [PprWidth-1:0]   cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  sensor_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  pulse_event;
  logic [CountWidth-1:0] pulse_total;
  logic [CountWidth-1:0] period_ticks;
  logic [RpmWidth-1:0]   rpm_value;
  logic                  rpm_valid;

  logic          level_queue[$];
  tach_reading_t want_readings[$];
  logic          req_taken = 1'b0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   mismatch_count = 0;

  logic [PprWidth-1:0]   ppr_q = 8'd1;
  logic                  prev_q = 1'b1;
  logic                  primed_q = 1'b0;
  logic                  edge_seen_q = 1'b0;
  logic [CountWidth-1:0] ticks_q = '0;
  logic [CountWidth-1:0] edges_q = '0;
  logic [CountWidth-1:0] period_q = '0;
  logic [RpmWidth-1:0]   rpm_q = '0;
  logic                  have_period_q = 1'b0;

  always #1 clk = ~clk;

  pulse_period_tachometer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sensor_level(sensor_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pulse_event(pulse_event),
    .pulse_total(pulse_total),
    .period_ticks(period_ticks),
    .rpm_value(rpm_value),
    .rpm_valid(rpm_valid)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Advances the tracked state by one tick and queues the reading it produces.
  task automatic tach_track(input logic level);
    tach_reading_t    r;
    longint unsigned  divisor;
    logic             fell;
    fell = 1'b0;
    if (!primed_q) begin
      prev_q = level;
      primed_q = 1'b1;
    end else begin
      if (ticks_q != '1) ticks_q++;
      if (prev_q && !level) begin
        fell = 1'b1;
        edges_q++;
        if (edge_seen_q) begin
          period_q = ticks_q;
          divisor = period_q;
          divisor = divisor * ((ppr_q == '0) ? 1 : ppr_q);
          rpm_q = (divisor == 0) ? '0 : RpmWidth'(RpmScale / divisor);
          have_period_q = 1'b1;
        end
        edge_seen_q = 1'b1;
        ticks_q = '0;
      end
      prev_q = level;
    end
    r.fell = fell;
    r.total = edges_q;
    r.period = period_q;
    r.rpm = rpm_q;
    r.rpm_ok = have_period_q;
    want_readings.push_back(r);
  endtask

  function automatic int run_length();
    int r = $urandom_range(99);
    if (r < 75) return $urandom_range(10, 1);
    if (r < 97) return $urandom_range(60, 11);
    return $urandom_range(300, 100);
  endfunction

  // Mostly clean square waves of random duty, with bursts of random levels mixed in.
  task automatic queue_pulse_train(input int n);
    int added;
    int high_len;
    int low_len;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 80) begin
        high_len = run_length();
        low_len = run_length();
        repeat (high_len) level_queue.push_back(1'b1);
        repeat (low_len) level_queue.push_back(1'b0);
        added += high_len + low_len;
      end else begin
        repeat ($urandom_range(8, 1)) begin
          level_queue.push_back(logic'($urandom_range(1, 0)));
          added++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (level_queue.size() != 0 || want_readings.size() != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && (!in_valid || req_taken)) begin
      if (level_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        sensor_level <= level_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tach_reading_t want;
    req_taken <= in_valid && in_ready;
    if (cfg_we) ppr_q = cfg_wdata;
    if (!rst && in_valid && in_ready) begin
      level_queue.delete(0);
      tach_track(sensor_level);
    end
    if (!rst && out_valid && out_ready) begin
      if (want_readings.size() == 0) begin
        report_mismatch("result with no request", 0, 0);
      end else begin
        want = want_readings.pop_front();
        if (pulse_event !== want.fell)
          report_mismatch("pulse_event", pulse_event, want.fell);
        if (pulse_total !== want.total)
          report_mismatch("pulse_total", pulse_total, want.total);
        if (period_ticks !== want.period)
          report_mismatch("period_ticks", period_ticks, want.period);
        if (rpm_value !== want.rpm)
          report_mismatch("rpm_value", rpm_value, want.rpm);
        if (rpm_valid !== want.rpm_ok)
          report_mismatch("rpm_valid", rpm_valid, want.rpm_ok);
      end
    end
  end

  initial begin
    logic [PprWidth-1:0] ppr_plan[NumPhases];
    logic directed_levels[13];
    directed_levels = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                        1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    ppr_plan = '{8'd255, 8'd0, 8'd1, 8'd2, PprWidth'($urandom_range(255, 1)),
                 8'd60, 8'd128, PprWidth'($urandom_range(255, 0))};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The priming tick is low, so the reset level must not produce an edge.
    foreach (directed_levels[i]) level_queue.push_back(directed_levels[i]);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      cfg_we <= 1'b1;
      cfg_wdata <= ppr_plan[p];
      @(negedge clk);
      cfg_we <= 1'b0;
      queue_pulse_train(TicksPerPhase);
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (want_readings.size() != 0)
      report_mismatch("results never delivered", want_readings.size(), 0);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/ptach_pkg.sv
hdl/ptach_ctrl.sv
hdl/ptach_datapath.sv
hdl/pulse_period_tachometer.sv
hdl/ptach_checker.sv
tb/sv/pulse_period_tachometer_tb.sv
